/* hw/rtl/dtxs_pkg.sv */
// Shared types, constants and key table builders for the dual table XOR stream cipher.
package dtxs_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t key_tab_t [256];

  // Command codes carried with each input word.
  localparam logic CmdTransform = 1'b0;
  localparam logic CmdClear     = 1'b1;

  // Configuration register indexes.
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegUseSeedKeys = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSeedValue   = 8'd1;
  localparam int CfgDataW = 32;

  // Control from the datapath to the key stream unit.
  typedef struct packed {
    logic rd_en;   // advance the table read registers
    logic step;    // a transform word was accepted
    logic clear;   // a clear command word was accepted
  } ks_ctrl_t;

  function automatic key_tab_t build_key_one();
    key_tab_t tab;
    logic [31:0] a;
    a = 32'd31;
    for (int i = 0; i < 256; i++) begin
      tab[i] = a[7:0];
      a = (32'd253 * a + 32'd32 * a * a + 32'd8) & 32'hFF;
    end
    return tab;
  endfunction

  function automatic key_tab_t build_key_two();
    key_tab_t tab;
    logic [31:0] b;
    b = 32'd63;
    for (int i = 0; i < 256; i++) begin
      tab[i] = b[7:0];
      b = (b * ((32'd122 * b + 32'd207) & 32'hFF) + 32'd229) & 32'hFF;
    end
    return tab;
  endfunction

  localparam key_tab_t KeyOne = build_key_one();
  localparam key_tab_t KeyTwo = build_key_two();

endpackage

/* hw/rtl/dtxs_if.sv */
// Valid/ready channel interfaces for the cipher input and result words.
interface dtxs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface dtxs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

/* hw/rtl/dual_table_xor_stream_cipher_unit.sv */
// Top level of the dual table XOR stream cipher: config, pipeline and result register.
// An accepted word passes the registered table read, then the output register, before its result is valid.
// Throughput: one word per cycle while the result side is not stalled.
// A clear command takes one slot and yields no result.
// Reset (rst, synchronous): counters to 0, config to 0, pipeline empty.
// Seed square is registered from the seed value register, so a seed write reaches it after seed_value.
module dual_table_xor_stream_cipher_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dtxs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dtxs_pkg::CfgDataW-1:0] cfg_data,
  dtxs_in_if.sink                       rx,
  dtxs_out_if.source                    tx
);

  // Configuration registers.
  logic        use_seed_keys;
  logic [31:0] seed_value;
  logic [31:0] seed_square;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_seed_keys <= 1'b0;
      seed_value    <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtxs_pkg::RegUseSeedKeys: use_seed_keys <= cfg_data[0];
        dtxs_pkg::RegSeedValue:   seed_value    <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Square of the seed, low 32 bits; one multiplier, registered.
  always_ff @(posedge clk) begin
    seed_square <= seed_value * seed_value;
  end

  // Pipeline control. Stage 1 holds the table read; the output register
  // holds the finished word. Stage 1 moves on whenever the output slot
  // is free or being drained, so input stays open back to back.
  logic s1_valid;
  logic s1_valid_next;

  logic            advance;
  logic            accept;
  dtxs_pkg::ks_ctrl_t ks_ctrl;
  dtxs_pkg::byte_t key_one;
  dtxs_pkg::byte_t key_two;
  logic [1:0]      low_lane;
  logic [1:0]      high_lane;
  dtxs_pkg::byte_t s1_data;

  assign advance  = !tx.valid || tx.ready;
  assign rx.ready = !s1_valid || advance;
  assign accept   = rx.valid && rx.ready;

  assign ks_ctrl.rd_en = rx.ready;
  assign ks_ctrl.step  = accept && (rx.command == dtxs_pkg::CmdTransform);
  assign ks_ctrl.clear = accept && (rx.command == dtxs_pkg::CmdClear);

  dtxs_keystream u_keystream (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ks_ctrl),
    .key_one   (key_one),
    .key_two   (key_two),
    .low_lane  (low_lane),
    .high_lane (high_lane)
  );

  // Stage 1 occupancy: only transform words carry on toward a result.
  always_comb begin
    s1_valid_next = s1_valid;
    if (rx.ready) begin
      s1_valid_next = ks_ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // Data byte rides alongside the table read.
  always_ff @(posedge clk) begin
    if (rx.ready) begin
      s1_data <= rx.data_byte;
    end
  end

  // Mix in both key bytes and, if use_seed_keys, the seed bytes selected by the low two bits of each position.
  dtxs_pkg::byte_t seed_byte;
  dtxs_pkg::byte_t square_byte;
  dtxs_pkg::byte_t mixed;

  assign seed_byte   = seed_value[{low_lane, 3'b000} +: 8];
  assign square_byte = seed_square[{high_lane, 3'b000} +: 8];

  always_comb begin
    mixed = s1_data ^ key_one ^ key_two;
    if (use_seed_keys) begin
      mixed = mixed ^ seed_byte ^ square_byte;
    end
  end

  // Output register: load when the slot frees up, hold while stalled.
  logic tx_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (advance) begin
      tx_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx.result_byte <= mixed;
    end
  end

  assign tx.valid = tx_valid;

endmodule

/* hw/rtl/dtxs_keystream.sv */
// Position counters and registered key table reads for the cipher.
module dtxs_keystream (
  input  logic                clk,
  input  logic                rst,
  input  dtxs_pkg::ks_ctrl_t  ctrl,
  output dtxs_pkg::byte_t     key_one,
  output dtxs_pkg::byte_t     key_two,
  output logic [1:0]          low_lane,
  output logic [1:0]          high_lane
);

  logic [7:0] low_position;
  logic [7:0] high_position;

  // Key tables: constant memories with a registered read.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      key_one   <= dtxs_pkg::KeyOne[low_position];
      key_two   <= dtxs_pkg::KeyTwo[high_position];
      low_lane  <= low_position[1:0];
      high_lane <= high_position[1:0];
    end
  end

  // Advance low on each transform step; carry into high on wrap. Reset or clear zeroes both.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      low_position  <= 8'd0;
      high_position <= 8'd0;
    end else if (ctrl.step) begin
      low_position <= low_position + 8'd1;
      if (low_position == 8'hFF) begin
        high_position <= high_position + 8'd1;
      end
    end
  end

endmodule

/* hw/rtl/dtxs_checker.sv */
// Port-level assertions for the cipher top level, bound in below.
module dtxs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // With the output slot empty, input is never blocked.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output slot empty");

  // A transform word accepted with the output slot empty reaches the output.
  a_result_arrives: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_command == dtxs_pkg::CmdTransform) && !out_valid
      |-> ##2 out_valid)
    else $error("transform word produced no result");

endmodule

bind dual_table_xor_stream_cipher_unit dtxs_checker u_dtxs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (rx.valid),
  .in_ready   (rx.ready),
  .in_command (rx.command),
  .out_valid  (tx.valid),
  .out_ready  (tx.ready),
  .out_byte   (tx.result_byte)
);
